/* hdl/rvs_pkg.sv */
// ----------------------------------------------------------------------------
// rvs_pkg
// Shared types and constants of the running variance scale block.
// ----------------------------------------------------------------------------
package rvs_pkg;

  localparam int unsigned MaxDims  = 64;
  localparam int unsigned AddrW    = $clog2(MaxDims);
  localparam int unsigned VarW     = 40;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [VarW-1:0] UnityQ16 = VarW'(65536);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE       = 3'd0,
    REG_BURN_IN    = 3'd1,
    REG_PERSISTENT = 3'd2,
    REG_POLE       = 3'd3,
    REG_FRAME_SIZE = 3'd4
  } cfg_reg_e;

  // Input item opcodes
  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_BACC,
    S_MA,
    S_MB,
    S_SQRT,
    S_DRD,
    S_DLOAD,
    S_DDIV,
    S_EMIT
  } state_e;

endpackage

/* hdl/rvs_if.sv */
// ----------------------------------------------------------------------------
// rvs channel interfaces
// Sample input, scale output and configuration write channels.
// ----------------------------------------------------------------------------
interface rvs_in_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic signed [15:0]               value;
  logic [rvs_pkg::AddrW-1:0]        element;
  modport source (output valid, op, value, element, input ready);
  modport sink   (input valid, op, value, element, output ready);
endinterface

interface rvs_out_if;
  logic                             valid;
  logic                             ready;
  logic [15:0]                      scale;
  logic [rvs_pkg::AddrW-1:0]        dimension;
  logic [7:0]                       frames_covered;
  logic                             last;
  modport source (output valid, scale, dimension, frames_covered, last, input ready);
  modport sink   (input valid, scale, dimension, frames_covered, last, output ready);
endinterface

interface rvs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rvs_pkg::CfgIdxW-1:0]      index;
  logic [rvs_pkg::CfgDataW-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/rvs_div.sv */
// ----------------------------------------------------------------------------
// rvs_div
// Restoring divider, one quotient bit per cycle, for the burn-in mean.
// ----------------------------------------------------------------------------
module rvs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rvs_pkg::VarW:0]    dividend_i,
  input  logic [7:0]                divisor_i,
  output logic                      done_o,
  output logic [rvs_pkg::VarW-1:0]  quotient_o
);

  localparam int unsigned Steps = rvs_pkg::VarW + 1;

  logic [rvs_pkg::VarW:0] quo_q;
  logic [7:0]             rem_q;
  logic [7:0]             div_q;
  logic [5:0]             cnt_q;
  logic                   busy_q;
  logic                   done_q;
  logic [8:0]             trial;
  logic                   fits;

  // Bring down the next dividend bit and try the subtraction
  assign trial = {rem_q, quo_q[rvs_pkg::VarW]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[rvs_pkg::VarW-1:0], fits};
      rem_q <= fits ? 8'(trial - {1'b0, div_q}) : trial[7:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[rvs_pkg::VarW-1:0];

endmodule

/* hdl/rvs_sqrt.sv */
// ----------------------------------------------------------------------------
// rvs_sqrt
// Bit-pair integer square root, one root bit per cycle, saturated to 16 bits.
// ----------------------------------------------------------------------------
module rvs_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rvs_pkg::VarW-1:0]  arg_i,
  output logic                      done_o,
  output logic [15:0]               root_o
);

  localparam int unsigned W     = rvs_pkg::VarW + 1;
  localparam int unsigned Steps = W / 2 + 1;

  logic [W-1:0] v_q;
  logic [W-1:0] root_q;
  logic [W-1:0] bit_q;
  logic [4:0]   cnt_q;
  logic         busy_q;
  logic         done_q;
  logic [W-1:0] trial;
  logic         fits;

  assign trial = root_q + bit_q;
  assign fits  = v_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Retire one bit pair per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= {1'b0, arg_i};
      root_q <= '0;
      bit_q  <= {1'b1, {(W-1){1'b0}}};
    end else if (busy_q) begin
      if (fits) begin
        v_q    <= v_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = (root_q > W'(65535)) ? 16'hFFFF : root_q[15:0];

endmodule

/* hdl/running_variance_scale_core.sv */
// ----------------------------------------------------------------------------
// running_variance_scale_core
// Per-dimension running variance with burn-in, giving sqrt scales in Q8.8.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one beat per sample (op, value, element) or restart item.
//   out_o : scale beats with dimension, frames_covered and last.
//   cfg_i : register writes, always ready; write only while idle.
// Flow: a restart or out-of-frame sample is taken in the idle state. A
//   fixed-mode sample goes straight to the emit state. A burn-in sample
//   that does not close the burn-in is squared and accumulated. An adaptive
//   sample makes three multiplier passes on the shared 17x40 multiplier,
//   runs the bit-serial square root, then emits and returns to idle.
//   Closing burn-in emits n beats, each through read and load, divide,
//   square root and the emit state.
// The input is not ready while an item is worked on; the output register
//   holds a beat while the receiver stalls and the sequencer waits on it.
// Reset sets registers to their defaults, all variances to 1.0 through
//   per-entry valid bits, and clears the burn-in count; no clearing pass.
// ----------------------------------------------------------------------------
module running_variance_scale_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  rvs_in_if.sink     in_i,
  rvs_out_if.source  out_o,
  rvs_cfg_if.sink    cfg_i
);

  localparam int unsigned AW = rvs_pkg::AddrW;
  localparam int unsigned VW = rvs_pkg::VarW;

  rvs_pkg::state_e state_q, state_d;

  logic        mode_q;
  logic [7:0]  bif_q;
  logic        pers_q;
  logic [15:0] pole_q;
  logic [6:0]  fsize_q;

  logic [15:0]   val_q;
  logic [AW-1:0] addr_q;
  logic [31:0]   x2_q;
  logic [56:0]   acc_q;
  logic [7:0]    cnt_q;
  logic          burned_q;
  logic          dump_q;
  logic [15:0]   res_q;
  logic [rvs_pkg::MaxDims-1:0] vld_q;

  logic [VW-1:0] mem_q [rvs_pkg::MaxDims];
  logic [VW-1:0] rdata_q;
  logic [AW-1:0] raddr;
  logic          mem_we;
  logic [VW-1:0] mem_wd;

  logic          out_valid_q;
  logic [15:0]   out_scale_q;
  logic [AW-1:0] out_dim_q;
  logic [7:0]    out_frames_q;
  logic          out_last_q;

  logic [6:0]    n_eff;
  logic [AW-1:0] last_dim;
  logic          in_acc;
  logic          burn_active;
  logic [VW-1:0] curvar;
  logic [16:0]   mag;
  logic [16:0]   mul_a;
  logic [VW-1:0] mul_b;
  logic [56:0]   prod;
  logic [57:0]   upd_sum;
  logic [7:0]    cnt_inc;
  logic          div_start, div_done;
  logic [VW-1:0] div_quo;
  logic          sqrt_start, sqrt_done;
  logic [VW-1:0] sqrt_arg;
  logic [15:0]   sqrt_root;
  logic          emit;
  logic          out_free;

  // Effective frame size: zero acts as one, capped at the store depth
  always_comb begin
    n_eff = fsize_q;
    if (fsize_q == 7'd0) n_eff = 7'd1;
    if (fsize_q > 7'(rvs_pkg::MaxDims)) n_eff = 7'(rvs_pkg::MaxDims);
  end
  assign last_dim = AW'(n_eff - 7'd1);

  assign in_acc      = in_i.valid && in_i.ready;
  assign burn_active = (bif_q != 8'd0) && !burned_q;
  assign curvar      = vld_q[addr_q] ? rdata_q : rvs_pkg::UnityQ16;
  assign mag         = val_q[15] ? 17'(17'h10000 - {1'b0, val_q}) : {1'b0, val_q};
  assign cnt_inc     = (cnt_q == 8'd255) ? 8'd255 : cnt_q + 8'd1;
  assign out_free    = !out_valid_q || out_o.ready;

  // Shared multiplier: square, pole term, complement term
  always_comb begin
    mul_a = mag;
    mul_b = VW'(mag);
    case (state_q)
      rvs_pkg::S_MA: begin
        mul_a = {1'b0, pole_q};
        mul_b = curvar;
      end
      rvs_pkg::S_MB: begin
        mul_a = 17'(17'h10000 - {1'b0, pole_q});
        mul_b = VW'(x2_q);
      end
      default: ;
    endcase
  end
  assign prod    = mul_a * mul_b;
  assign upd_sum = {1'b0, acc_q} + {1'b0, prod} + 58'd32768;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    mem_we     = 1'b0;
    mem_wd     = '0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    sqrt_arg   = '0;
    emit       = 1'b0;
    case (state_q)
      rvs_pkg::S_IDLE: begin
        if (in_acc && in_i.op == rvs_pkg::OP_SAMPLE && {1'b0, in_i.element} < n_eff) begin
          state_d = mode_q ? rvs_pkg::S_EMIT : rvs_pkg::S_SQ;
        end
      end
      rvs_pkg::S_SQ: begin
        state_d = burn_active ? rvs_pkg::S_BACC : rvs_pkg::S_MA;
      end
      rvs_pkg::S_BACC: begin
        mem_we  = 1'b1;
        mem_wd  = (cnt_q == 8'd0) ? VW'(x2_q) : curvar + VW'(x2_q);
        state_d = rvs_pkg::S_IDLE;
        if (addr_q == last_dim && cnt_inc >= bif_q) state_d = rvs_pkg::S_DRD;
      end
      rvs_pkg::S_MA: begin
        state_d = rvs_pkg::S_MB;
      end
      rvs_pkg::S_MB: begin
        mem_we     = 1'b1;
        mem_wd     = upd_sum[55:16];
        sqrt_start = 1'b1;
        sqrt_arg   = upd_sum[55:16];
        state_d    = rvs_pkg::S_SQRT;
      end
      rvs_pkg::S_SQRT: begin
        if (sqrt_done) state_d = rvs_pkg::S_EMIT;
      end
      rvs_pkg::S_DRD: begin
        state_d = rvs_pkg::S_DLOAD;
      end
      rvs_pkg::S_DLOAD: begin
        div_start = 1'b1;
        state_d   = rvs_pkg::S_DDIV;
      end
      rvs_pkg::S_DDIV: begin
        if (div_done) begin
          mem_we     = 1'b1;
          mem_wd     = div_quo;
          sqrt_start = 1'b1;
          sqrt_arg   = div_quo;
          state_d    = rvs_pkg::S_SQRT;
        end
      end
      rvs_pkg::S_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = (dump_q && addr_q != last_dim) ? rvs_pkg::S_DRD : rvs_pkg::S_IDLE;
        end
      end
      default: state_d = rvs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rvs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      bif_q   <= 8'd20;
      pers_q  <= 1'b0;
      pole_q  <= 16'd64881;
      fsize_q <= 7'd39;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        rvs_pkg::REG_MODE:       mode_q  <= cfg_i.data[0];
        rvs_pkg::REG_BURN_IN:    bif_q   <= cfg_i.data[7:0];
        rvs_pkg::REG_PERSISTENT: pers_q  <= cfg_i.data[0];
        rvs_pkg::REG_POLE:       pole_q  <= cfg_i.data;
        rvs_pkg::REG_FRAME_SIZE: fsize_q <= cfg_i.data[6:0];
        default: ;
      endcase
    end
  end
  assign cfg_i.ready = 1'b1;

  // Control state: burn-in progress, valid bits, output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      burned_q    <= 1'b0;
      dump_q      <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (mem_we) vld_q[addr_q] <= 1'b1;
      if (in_acc) begin
        dump_q <= 1'b0;
        if (in_i.op == rvs_pkg::OP_RESTART && (mode_q || !pers_q)) begin
          vld_q    <= '0;
          cnt_q    <= '0;
          burned_q <= 1'b0;
        end
      end
      if (state_q == rvs_pkg::S_BACC && addr_q == last_dim) begin
        cnt_q <= cnt_inc;
        if (cnt_inc >= bif_q) dump_q <= 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        if (dump_q && addr_q == last_dim) burned_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      val_q  <= in_i.value;
      addr_q <= in_i.element;
      res_q  <= 16'd256;
    end
    if (state_q == rvs_pkg::S_SQ) x2_q <= prod[31:0];
    if (state_q == rvs_pkg::S_MA) acc_q <= prod;
    if (state_q == rvs_pkg::S_BACC && addr_q == last_dim && cnt_inc >= bif_q) addr_q <= '0;
    if (state_q == rvs_pkg::S_SQRT && sqrt_done) res_q <= sqrt_root;
    if (emit) begin
      out_scale_q  <= res_q;
      out_dim_q    <= addr_q;
      out_frames_q <= dump_q ? bif_q : 8'd1;
      out_last_q   <= dump_q ? (addr_q == last_dim) : 1'b1;
      if (dump_q && addr_q != last_dim) addr_q <= addr_q + AW'(1);
    end
  end

  // Variance store: one write port, one registered read port
  assign raddr = (state_q == rvs_pkg::S_IDLE) ? in_i.element : addr_q;
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[addr_q] <= mem_wd;
    rdata_q <= mem_q[raddr];
  end

  rvs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({1'b0, curvar} + {34'd0, bif_q[7:1]}),
    .divisor_i  (bif_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  rvs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .arg_i   (sqrt_arg),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign in_i.ready           = (state_q == rvs_pkg::S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.scale          = out_scale_q;
  assign out_o.dimension      = out_dim_q;
  assign out_o.frames_covered = out_frames_q;
  assign out_o.last           = out_last_q;

endmodule

/* bench/rvs_checker.sv */
// ----------------------------------------------------------------------------
// rvs_checker
// Watches the sample, scale and register channels of the running variance
// scale core. Predicts every scale beat from the accepted samples and
// compares the beats in order, counting mismatches for the bench top.
// ----------------------------------------------------------------------------
module rvs_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rvs_in_if    in_mon,
  rvs_out_if   out_mon,
  rvs_cfg_if   cfg_mon,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] scale;
    logic [5:0]  dimension;
    logic [7:0]  frames;
    logic        last;
  } scale_beat_t;

  // Predicted state and register copies
  logic [rvs_pkg::VarW-1:0] var_q [rvs_pkg::MaxDims];
  logic [7:0]      burn_cnt;
  logic            burned;
  logic            mode_fixed;
  logic [7:0]      burn_len;
  logic            keep_var;
  logic [15:0]     pole_q;
  logic [6:0]      fsize_q;

  scale_beat_t scale_q[$];
  int          fails;

  assign fail_count_o = fails;

  // Floor square root of a Q16.16 word, saturated to Q8.8
  function automatic logic [15:0] root_of(logic [rvs_pkg::VarW-1:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= 64'(v)) r = t;
    end
    return (r > 64'd65535) ? 16'hFFFF : r[15:0];
  endfunction

  task automatic unity_reset();
    for (int i = 0; i < rvs_pkg::MaxDims; i++) var_q[i] = rvs_pkg::UnityQ16;
    burn_cnt = 0;
    burned   = 1'b0;
  endtask

  // Advance the prediction by one accepted beat
  task automatic take_item(logic op, logic [15:0] raw, logic [5:0] el);
    int unsigned n;
    logic [15:0] mag;
    logic [63:0] sq;
    logic [63:0] acc;
    n = (fsize_q == 0) ? 1
      : ((fsize_q > rvs_pkg::MaxDims) ? rvs_pkg::MaxDims : fsize_q);
    if (op == rvs_pkg::OP_RESTART) begin
      if (mode_fixed || !keep_var) unity_reset();
      return;
    end
    if (el >= n) return;
    if (mode_fixed) begin
      scale_q.push_back('{16'd256, el, 8'd1, 1'b1});
      return;
    end
    mag = raw[15] ? (16'h0 - raw) : raw;
    sq  = 64'(mag) * 64'(mag);
    if (burn_len != 0 && !burned) begin
      if (burn_cnt == 0) var_q[el] = sq[rvs_pkg::VarW-1:0];
      else var_q[el] = var_q[el] + sq[rvs_pkg::VarW-1:0];
      if (el == n - 1) begin
        if (burn_cnt != 8'hFF) burn_cnt++;
        if (burn_cnt >= burn_len) begin
          for (int i = 0; i < n; i++) begin
            acc = (64'(var_q[i]) + 64'(burn_len / 2)) / 64'(burn_len);
            var_q[i] = acc[rvs_pkg::VarW-1:0];
            scale_q.push_back('{root_of(var_q[i]), 6'(i), burn_len, 1'(i == n - 1)});
          end
          burned = 1'b1;
        end
      end
      return;
    end
    acc = 64'(pole_q) * 64'(var_q[el]) + (64'd65536 - 64'(pole_q)) * sq + 64'd32768;
    var_q[el] = acc[16 +: rvs_pkg::VarW];
    scale_q.push_back('{root_of(var_q[el]), el, 8'd1, 1'b1});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_fixed = 1'b0;
      burn_len   = 8'd20;
      keep_var   = 1'b0;
      pole_q     = 16'd64881;
      fsize_q    = 7'd39;
      unity_reset();
      scale_q.delete();
      fails = 0;
    end else begin
      // Compare a delivered beat with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        scale_beat_t got;
        scale_beat_t want;
        got = '{out_mon.scale, out_mon.dimension, out_mon.frames_covered, out_mon.last};
        if (scale_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected beat: expected none, actual scale=%0d dim=%0d fr=%0d last=%0d",
                   $realtime, got.scale, got.dimension, got.frames, got.last);
        end else begin
          want = scale_q.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: mismatch: expected scale=%0d dim=%0d fr=%0d last=%0d, actual scale=%0d dim=%0d fr=%0d last=%0d",
                     $realtime, want.scale, want.dimension, want.frames, want.last,
                     got.scale, got.dimension, got.frames, got.last);
          end
        end
      end
      // Register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (rvs_pkg::cfg_reg_e'(cfg_mon.index))
          rvs_pkg::REG_MODE:       mode_fixed = cfg_mon.data[0];
          rvs_pkg::REG_BURN_IN:    burn_len   = cfg_mon.data[7:0];
          rvs_pkg::REG_PERSISTENT: keep_var   = cfg_mon.data[0];
          rvs_pkg::REG_POLE:       pole_q     = cfg_mon.data;
          rvs_pkg::REG_FRAME_SIZE: fsize_q    = cfg_mon.data[6:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        take_item(in_mon.op, in_mon.value, in_mon.element);
    end
    // Publish the number of beats still owed
    pending_o = scale_q.size();
  end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives samples, restarts and register writes into the running variance
// scale core: a directed opening over the corner cases, then randomised
// frames under several register settings, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  bit   no_gaps;

  rvs_in_if  in_ch ();
  rvs_out_if out_ch ();
  rvs_cfg_if cfg_ch ();

  running_variance_scale_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  rvs_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_mon      (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Give up after a generous fixed time
  initial begin
    #200ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: stall a random number of cycles before each beat
  initial begin
    int unsigned n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 13);
      if (n != 0) begin
        out_ch.ready = 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      @(negedge clk_i);
    end
  end

  task automatic send_item(rvs_pkg::op_e op, logic [15:0] val, logic [5:0] el);
    int unsigned n;
    n = no_gaps ? 0 : $urandom_range(0, 13);
    if (n != 0) begin
      in_ch.valid = 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_ch.op      = op;
    in_ch.value   = val;
    in_ch.element = el;
    in_ch.valid   = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Hold the input until every scale is back and the core has gone quiet
  task automatic settle();
    in_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_reg(rvs_pkg::cfg_reg_e idx, logic [15:0] data);
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 511)) - 16'd256;
      1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Stimulus
  initial begin
    int unsigned fs;
    int unsigned sent;
    in_ch.valid   = 1'b0;
    in_ch.op      = rvs_pkg::OP_SAMPLE;
    in_ch.value   = '0;
    in_ch.element = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = rvs_pkg::REG_MODE;
    cfg_ch.data   = '0;
    no_gaps       = 1'b0;
    rst_ni        = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: two-frame burn-in with extreme samples, then adaptation
    write_reg(rvs_pkg::REG_FRAME_SIZE, 16'd4);
    write_reg(rvs_pkg::REG_BURN_IN, 16'd2);
    write_reg(rvs_pkg::REG_POLE, 16'd65535);
    write_reg(rvs_pkg::REG_PERSISTENT, 16'd0);
    write_reg(rvs_pkg::REG_MODE, 16'd0);
    send_item(rvs_pkg::OP_SAMPLE, 16'h8000, 6'd0);
    send_item(rvs_pkg::OP_SAMPLE, 16'h7FFF, 6'd1);
    send_item(rvs_pkg::OP_SAMPLE, 16'h0000, 6'd63);
    send_item(rvs_pkg::OP_SAMPLE, 16'hFFFF, 6'd3);
    send_item(rvs_pkg::OP_SAMPLE, 16'h8000, 6'd0);
    send_item(rvs_pkg::OP_SAMPLE, 16'h0100, 6'd2);
    send_item(rvs_pkg::OP_SAMPLE, 16'h7FFF, 6'd3);
    send_item(rvs_pkg::OP_SAMPLE, 16'h8000, 6'd1);
    send_item(rvs_pkg::OP_SAMPLE, 16'h0000, 6'd2);
    settle();
    write_reg(rvs_pkg::REG_POLE, 16'd1);
    send_item(rvs_pkg::OP_SAMPLE, 16'h7FFF, 6'd0);
    send_item(rvs_pkg::OP_SAMPLE, 16'h0001, 6'd1);
    settle();
    write_reg(rvs_pkg::REG_POLE, 16'd0);
    send_item(rvs_pkg::OP_SAMPLE, 16'hFFFF, 6'd2);
    settle();
    // Persistent restart keeps the variance, then a plain one clears it
    write_reg(rvs_pkg::REG_PERSISTENT, 16'd1);
    send_item(rvs_pkg::OP_RESTART, 16'h1234, 6'd0);
    send_item(rvs_pkg::OP_SAMPLE, 16'h0200, 6'd1);
    settle();
    write_reg(rvs_pkg::REG_BURN_IN, 16'd0);
    write_reg(rvs_pkg::REG_PERSISTENT, 16'd0);
    send_item(rvs_pkg::OP_RESTART, 16'h0000, 6'd0);
    send_item(rvs_pkg::OP_SAMPLE, 16'h0300, 6'd3);
    settle();
    // Fixed mode, restart in fixed mode, frame size zero and oversize
    write_reg(rvs_pkg::REG_MODE, 16'd1);
    write_reg(rvs_pkg::REG_FRAME_SIZE, 16'd0);
    send_item(rvs_pkg::OP_SAMPLE, 16'h7FFF, 6'd0);
    send_item(rvs_pkg::OP_SAMPLE, 16'h7FFF, 6'd1);
    send_item(rvs_pkg::OP_RESTART, 16'h0000, 6'd0);
    settle();
    write_reg(rvs_pkg::REG_FRAME_SIZE, 16'd127);
    send_item(rvs_pkg::OP_SAMPLE, 16'h8000, 6'd63);
    settle();
    // Burn-in length lowered part way through
    write_reg(rvs_pkg::REG_MODE, 16'd0);
    write_reg(rvs_pkg::REG_FRAME_SIZE, 16'd2);
    write_reg(rvs_pkg::REG_BURN_IN, 16'd255);
    send_item(rvs_pkg::OP_SAMPLE, 16'h0400, 6'd0);
    send_item(rvs_pkg::OP_SAMPLE, 16'hFC00, 6'd1);
    send_item(rvs_pkg::OP_SAMPLE, 16'h0800, 6'd1);
    settle();
    write_reg(rvs_pkg::REG_BURN_IN, 16'd1);
    send_item(rvs_pkg::OP_SAMPLE, 16'h0010, 6'd1);
    settle();

    // Random phases of frames, with restarts and stray elements
    sent = 0;
    for (int ph = 0; sent < 410; ph++) begin
      no_gaps = (ph % 4 == 3);
      write_reg(rvs_pkg::REG_MODE, 16'($urandom_range(0, 5) == 0));
      write_reg(rvs_pkg::REG_PERSISTENT, 16'($urandom_range(0, 1)));
      write_reg(rvs_pkg::REG_BURN_IN, ($urandom_range(0, 7) == 0) ? 16'd255
                                                                 : 16'($urandom_range(0, 4)));
      case ($urandom_range(0, 3))
        0: write_reg(rvs_pkg::REG_POLE, 16'($urandom_range(0, 1)) ? 16'hFFFF : 16'd0);
        1: write_reg(rvs_pkg::REG_POLE, 16'd64881);
        default: write_reg(rvs_pkg::REG_POLE, 16'($urandom));
      endcase
      case ($urandom_range(0, 9))
        0: fs = 64;
        1: fs = 127;
        default: fs = $urandom_range(1, 8);
      endcase
      write_reg(rvs_pkg::REG_FRAME_SIZE, 16'(fs));
      if (fs > 64) fs = 64;
      for (int f = 0; f < ((fs > 8) ? 1 : 6); f++) begin
        for (int e = 0; e < fs; e++) begin
          case ($urandom_range(0, 19))
            0: send_item(rvs_pkg::OP_RESTART, 16'($urandom), 6'($urandom));
            1: send_item(rvs_pkg::OP_SAMPLE, rand_value(), 6'($urandom_range(fs - 1, 63)));
            default: send_item(rvs_pkg::OP_SAMPLE, rand_value(), 6'(e));
          endcase
          sent++;
        end
      end
      settle();
    end

    no_gaps = 1'b0;
    in_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
